/* src/assert_macros.svh */
// Assertion macros shared by the bank decoder top level and its configuration space module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define PBMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define PBMD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PBMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pbmd_pkg.sv */
// Types and constants of the host bridge bank decoder
`timescale 1ns / 1ps

package pbmd_pkg;

	localparam int BANK_COUNT_DEF = 8;
	localparam int NumBankRegs    = 8;

	// Request kinds
	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_RAM_SIZE = 1'b0;
	localparam logic CFG_NUM_BASE = 1'b1;

	localparam logic [30:0] RAM_SIZE_RST = 31'd33554432;
	localparam logic [7:0]  NUM_BASE_RST = 8'd1;

	// Configuration space offsets
	localparam logic [7:0] OFF_ID       = 8'h00;
	localparam logic [7:0] OFF_CLASS    = 8'h08;
	localparam logic [7:0] OFF_ENABLE   = 8'hA0;
	localparam logic [7:0] OFF_PICR1    = 8'hA8;
	localparam logic [7:0] OFF_PICR2    = 8'hAC;
	localparam logic [7:0] OFF_MCCR1    = 8'hF0;
	localparam logic [7:0] OFF_MCCR2    = 8'hF4;
	localparam logic [7:0] OFF_MCCR3    = 8'hF8;
	localparam logic [7:0] OFF_MCCR4    = 8'hFC;
	localparam logic [2:0] BANK_WIN_HI  = 3'b100;

	// Fixed read words
	localparam logic [31:0] WORD_ID    = 32'h0001_1057;
	localparam logic [31:0] WORD_CLASS = 32'h0600_0000;
	localparam logic [31:0] WORD_PICR1 = 32'hFF00_0010;
	localparam logic [31:0] WORD_PICR2 = 32'h000C_060C;
	localparam logic [31:0] WORD_MCCR1 = 32'hFF02_0000;
	localparam logic [31:0] WORD_MCCR2 = 32'h0000_0003;
	localparam logic [31:0] WORD_MCCR4 = 32'h0010_0000;

	// Window geometry
	localparam logic [31:0] MIN_WINDOW = 32'h0010_0000;
	localparam logic [19:0] WIN_FILL   = 20'hF_FFFF;

	typedef logic [NumBankRegs-1:0][31:0] bank_regs_t;

	typedef struct packed {
		logic        hit;
		logic [8:0]  number;
		logic [29:0] offset;
	} dec_result_t;

endpackage

/* src/pci_bridge_memory_bank_decoder.sv */
// Top level of the host bridge configuration space and bank decoder
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one request per clock while the output is not stalled: config read,
// config write or address decode. A request is registered on entry and its
// result is registered on exit; back-to-back requests stream at one per
// cycle unless m_tready stalls the output. While a result waits, the input
// register still takes one more request. A config write takes effect for
// the very next request. The decode compares the address against all bank
// windows in parallel within the cycle between the two registers. The
// register write port (ram_size, bank_number_base) is always ready and is
// meant to be used while idle.
module pci_bridge_memory_bank_decoder #(
	parameter int BANK_COUNT = pbmd_pkg::BANK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // action
	input  logic [79:0] s_tdata,   // function_number, config_offset, write_data, cpu_address
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // read_data, bank_hit, bank_number, ram_offset
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [2:0]  func_s1;
	logic [7:0]  offset_s1;
	logic [31:0] wdata_s1;
	logic [29:0] addr_s1;

	logic        valid_s2;
	logic [31:0] read_data_s2;
	pbmd_pkg::dec_result_t dec_s2;

	logic [30:0] ram_size_q;
	logic [7:0]  num_base_q;

	logic        adv_s2;
	logic        adv_s1;
	logic        func0;
	logic        wr_en;
	logic [31:0] cfg_rd;
	logic [7:0]  enable_mask;
	pbmd_pkg::bank_regs_t  bank_regs;
	pbmd_pkg::dec_result_t dec;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign func0    = (func_s1 == 3'd0);
	assign wr_en    = adv_s1 && func0 && (action_s1 == pbmd_pkg::ACT_WRITE);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= pbmd_pkg::RAM_SIZE_RST;
			num_base_q <= pbmd_pkg::NUM_BASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pbmd_pkg::CFG_RAM_SIZE: ram_size_q <= cfg_data[30:0];
				pbmd_pkg::CFG_NUM_BASE: num_base_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			func_s1   <= s_tdata[2:0];
			offset_s1 <= s_tdata[10:3];
			wdata_s1  <= s_tdata[42:11];
			addr_s1   <= s_tdata[72:43];
		end
	end

	pbmd_cfg_space u_cfg_space (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.offset      (offset_s1),
		.wr_data     (wdata_s1),
		.rd_data     (cfg_rd),
		.bank_regs   (bank_regs),
		.enable_mask (enable_mask)
	);

	pbmd_bank_decode #(
		.BANK_COUNT (BANK_COUNT)
	) u_bank_decode (
		.bank_regs   (bank_regs),
		.enable_mask (enable_mask),
		.ram_size    (ram_size_q),
		.num_base    (num_base_q),
		.addr        (addr_s1),
		.result      (dec)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_s2 <= (action_s1 == pbmd_pkg::ACT_READ && func0) ? cfg_rd : '0;
			dec_s2       <= (action_s1 == pbmd_pkg::ACT_DECODE) ? dec : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {dec_s2.offset, dec_s2.number, dec_s2.hit, read_data_s2};

	`PBMD_ASSERT_NEXT(a_adv_fills_s2, adv_s1, valid_s2, "request lost between stages")
	`PBMD_ASSERT_IMPL(a_hit_no_read, valid_s2 && dec_s2.hit, read_data_s2 == '0, "hit with read data")
	`PBMD_ASSERT_IMPL(a_miss_clean, valid_s2 && !dec_s2.hit, (dec_s2.number == '0) && (dec_s2.offset == '0), "miss carries bank fields")
	`PBMD_ASSERT(a_ready_when_room, !valid_s1 |-> s_tready, "input stalled with empty stage")

endmodule

/* src/pbmd_cfg_space.sv */
// Configuration space registers and read multiplexer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbmd_cfg_space (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [7:0]           offset,
	input  logic [31:0]          wr_data,
	output logic [31:0]          rd_data,
	output pbmd_pkg::bank_regs_t bank_regs,
	output logic [7:0]           enable_mask
);

	pbmd_pkg::bank_regs_t bank_regs_q;
	logic [7:0]           enable_q;
	logic                 in_bank_win;

	assign in_bank_win = (offset[7:5] == pbmd_pkg::BANK_WIN_HI) && (offset[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_regs_q <= '0;
			enable_q    <= '0;
		end else if (wr_en) begin
			if (in_bank_win) begin
				bank_regs_q[offset[4:2]] <= wr_data;
			end else if (offset == pbmd_pkg::OFF_ENABLE) begin
				enable_q <= wr_data[7:0];
			end
		end
	end

	always_comb begin
		rd_data = '0;
		if (in_bank_win) begin
			rd_data = bank_regs_q[offset[4:2]];
		end else begin
			unique case (offset)
				pbmd_pkg::OFF_ID:     rd_data = pbmd_pkg::WORD_ID;
				pbmd_pkg::OFF_CLASS:  rd_data = pbmd_pkg::WORD_CLASS;
				pbmd_pkg::OFF_ENABLE: rd_data = {24'h0, enable_q};
				pbmd_pkg::OFF_PICR1:  rd_data = pbmd_pkg::WORD_PICR1;
				pbmd_pkg::OFF_PICR2:  rd_data = pbmd_pkg::WORD_PICR2;
				pbmd_pkg::OFF_MCCR1:  rd_data = pbmd_pkg::WORD_MCCR1;
				pbmd_pkg::OFF_MCCR2:  rd_data = pbmd_pkg::WORD_MCCR2;
				pbmd_pkg::OFF_MCCR3:  rd_data = '0;
				pbmd_pkg::OFF_MCCR4:  rd_data = pbmd_pkg::WORD_MCCR4;
				default:              rd_data = '0;
			endcase
		end
	end

	assign bank_regs   = bank_regs_q;
	assign enable_mask = enable_q;

	`PBMD_ASSERT_NEXT(a_enable_wr, wr_en && (offset == pbmd_pkg::OFF_ENABLE), enable_q == $past(wr_data[7:0]), "enable write lost")
	`PBMD_ASSERT_NEXT(a_regs_hold, !wr_en, $stable(bank_regs_q) && $stable(enable_q), "registers changed without write")

endmodule

/* src/pbmd_bank_decode.sv */
// Parallel window compare over all banks, highest bank wins
`timescale 1ns / 1ps

module pbmd_bank_decode #(
	parameter int BANK_COUNT = pbmd_pkg::BANK_COUNT_DEF
) (
	input  pbmd_pkg::bank_regs_t  bank_regs,
	input  logic [7:0]            enable_mask,
	input  logic [30:0]           ram_size,
	input  logic [7:0]            num_base,
	input  logic [29:0]           addr,
	output pbmd_pkg::dec_result_t result
);

	always_comb begin
		logic [2:0]  idx;
		logic [1:0]  lane_sel;
		logic [2:0]  grp;
		logic [7:0]  st_byte;
		logic [7:0]  st_ext;
		logic [7:0]  en_byte;
		logic [7:0]  en_ext;
		logic [31:0] win_start;
		logic [31:0] win_end;
		logic [31:0] lim_sum;
		logic [31:0] lim;
		logic [31:0] end_eff;
		logic [31:0] min_end;
		logic [31:0] addr_w;

		result = '0;
		addr_w = {2'b00, addr};
		for (int b = 0; b < BANK_COUNT; b++) begin
			idx      = 3'(b);
			lane_sel = idx[1:0];
			grp      = {2'b00, idx[2]};
			st_byte  = bank_regs[grp][{lane_sel, 3'b000} +: 8];
			st_ext   = bank_regs[grp + 3'd2][{lane_sel, 3'b000} +: 8];
			en_byte  = bank_regs[grp + 3'd4][{lane_sel, 3'b000} +: 8];
			en_ext   = bank_regs[grp + 3'd6][{lane_sel, 3'b000} +: 8];
			win_start = {2'b00, st_ext[1:0], st_byte, 20'h0};
			win_end   = {2'b00, en_ext[1:0], en_byte, pbmd_pkg::WIN_FILL};
			// clamp end to start plus RAM size minus one, floor at zero
			lim_sum  = win_start + {1'b0, ram_size};
			lim      = (lim_sum == '0) ? '0 : lim_sum - 32'd1;
			end_eff  = (lim < win_end) ? lim : win_end;
			min_end  = win_start + pbmd_pkg::MIN_WINDOW;
			if (enable_mask[idx] && (num_base != '0) && (min_end <= end_eff)
					&& (addr_w >= win_start) && (addr_w <= end_eff)) begin
				result.hit    = 1'b1;
				result.number = {6'b0, idx} + {1'b0, num_base};
				result.offset = addr - win_start[29:0];
			end
		end
	end

endmodule

/* tb/pci_bridge_memory_bank_decoder_test.sv */
// Self-checking bench for the bank decoder: config space reads and writes, bank window decodes
`timescale 1ns / 1ps

module pci_bridge_memory_bank_decoder_test;

	localparam logic [1:0] ACT_NONE       = 2'd3;
	localparam logic [7:0] OFF_BANK_FIRST = 8'h80;
	localparam logic [7:0] OFF_BANK_LAST  = 8'h9C;
	localparam logic [7:0] OFF_UNUSED     = 8'hA4;
	localparam logic [7:0] FIXED_OFFSETS [8] = '{pbmd_pkg::OFF_ID, pbmd_pkg::OFF_CLASS,
		pbmd_pkg::OFF_PICR1, pbmd_pkg::OFF_PICR2, pbmd_pkg::OFF_MCCR1, pbmd_pkg::OFF_MCCR2,
		pbmd_pkg::OFF_MCCR3, pbmd_pkg::OFF_MCCR4};
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int          PHASES          = 5;
	localparam int          ITEMS_PER_PHASE = 390;

	typedef struct {
		logic [1:0]  action;
		logic [2:0]  func;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [29:0] addr;
	} request_t;

	typedef struct {
		logic [31:0] read_data;
		logic        hit;
		logic [8:0]  number;
		logic [29:0] offset;
	} response_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	class bridge_scoreboard;
		logic [30:0] ram_size;
		logic [7:0]  num_base;
		logic [31:0] bank_regs [pbmd_pkg::NumBankRegs];
		logic [7:0]  enable_mask;
		response_t   expected_responses[$];
		int          errors;

		function new();
			ram_size = pbmd_pkg::RAM_SIZE_RST;
			num_base = pbmd_pkg::NUM_BASE_RST;
			enable_mask = '0;
			errors = 0;
			foreach (bank_regs[i])
				bank_regs[i] = '0;
		endfunction

		function void set_register(logic idx, logic [31:0] val);
			if (idx == pbmd_pkg::CFG_RAM_SIZE)
				ram_size = val[30:0];
			else
				num_base = val[7:0];
		endfunction

		// One byte lane per bank; banks 4-7 live in the odd register of each pair
		function logic [7:0] lane(int reg_base, int bank);
			return bank_regs[(reg_base + bank / 4) % pbmd_pkg::NumBankRegs][(bank % 4) * 8 +: 8];
		endfunction

		function bit is_bank_offset(logic [7:0] off);
			return off >= OFF_BANK_FIRST && off <= OFF_BANK_LAST && off[1:0] == 2'b00;
		endfunction

		function logic [31:0] config_word(logic [7:0] off);
			if (is_bank_offset(off))
				return bank_regs[off[4:2]];
			case (off)
				pbmd_pkg::OFF_ID:     return pbmd_pkg::WORD_ID;
				pbmd_pkg::OFF_CLASS:  return pbmd_pkg::WORD_CLASS;
				pbmd_pkg::OFF_ENABLE: return {24'd0, enable_mask};
				pbmd_pkg::OFF_PICR1:  return pbmd_pkg::WORD_PICR1;
				pbmd_pkg::OFF_PICR2:  return pbmd_pkg::WORD_PICR2;
				pbmd_pkg::OFF_MCCR1:  return pbmd_pkg::WORD_MCCR1;
				pbmd_pkg::OFF_MCCR2:  return pbmd_pkg::WORD_MCCR2;
				pbmd_pkg::OFF_MCCR4:  return pbmd_pkg::WORD_MCCR4;
				default:              return '0;
			endcase
		endfunction

		function response_t decode(logic [29:0] addr);
			response_t res;
			logic [63:0] win_lo, win_hi, lim;
			res = '{default: '0};
			if (num_base == '0)
				return res;
			// later banks overwrite earlier hits, so the highest one wins
			for (int b = 0; b < pbmd_pkg::BANK_COUNT_DEF; b++) begin
				if (!enable_mask[b])
					continue;
				win_lo = (64'(lane(0, b)) << 20) | (64'(lane(2, b) & 8'h03) << 28);
				win_hi = (64'(lane(4, b)) << 20) | (64'(lane(6, b) & 8'h03) << 28)
					| 64'(pbmd_pkg::WIN_FILL);
				lim = win_lo + 64'(ram_size);
				lim = (lim > 0) ? lim - 1 : 64'd0;
				if (lim < win_hi)
					win_hi = lim;
				if (win_lo + 64'(pbmd_pkg::MIN_WINDOW) > win_hi)
					continue;
				if (64'(addr) >= win_lo && 64'(addr) <= win_hi) begin
					res.hit = 1'b1;
					res.number = 9'(b + int'(num_base));
					res.offset = 30'(64'(addr) - win_lo);
				end
			end
			return res;
		endfunction

		function void note_request(request_t r);
			response_t res;
			res = '{default: '0};
			case (r.action)
				pbmd_pkg::ACT_READ: if (r.func == '0)
					res.read_data = config_word(r.offset);
				pbmd_pkg::ACT_WRITE: if (r.func == '0) begin
					if (is_bank_offset(r.offset))
						bank_regs[r.offset[4:2]] = r.wdata;
					else if (r.offset == pbmd_pkg::OFF_ENABLE)
						enable_mask = r.wdata[7:0];
				end
				pbmd_pkg::ACT_DECODE: res = decode(r.addr);
				default: ;
			endcase
			expected_responses.push_back(res);
		endfunction

		function void check_result(response_t got);
			response_t want;
			if (expected_responses.size() == 0) begin
				$error("unexpected result: read_data %h hit %b", got.read_data, got.hit);
				errors++;
				return;
			end
			want = expected_responses.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data expected %h got %h", want.read_data, got.read_data);
				errors++;
			end
			if (got.hit !== want.hit) begin
				$error("bank_hit expected %b got %b", want.hit, got.hit);
				errors++;
			end
			if (got.number !== want.number) begin
				$error("bank_number expected %0d got %0d", want.number, got.number);
				errors++;
			end
			if (got.offset !== want.offset) begin
				$error("ram_offset expected %h got %h", want.offset, got.offset);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	bridge_scoreboard sb = new();
	int               burst_left = 0;
	int unsigned      cycle_count = 0;
	rx_mode_t         rx_mode = RX_FREE;
	logic [5:0]       rx_tick = '0;

	pci_bridge_memory_bank_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pci_bridge_memory_bank_decoder_test failed");
			$finish;
		end
	end

	// Receiver backpressure: switch to a randomly picked stall style each time the 6-bit tick counter wraps
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 6'd1;
			if (rx_tick == '1)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_FREE:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom);
				RX_SPARSE: m_tready <= (rx_tick[2:0] == 3'd0);
				default:   m_tready <= (rx_tick[4:3] != 2'b11) && ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{m_tdata[31:0], m_tdata[32], m_tdata[41:33], m_tdata[71:42]});
	end

	function automatic request_t make_request(logic [1:0] action, logic [2:0] func,
			logic [7:0] offset, logic [31:0] wdata, logic [29:0] addr);
		request_t r;
		r.action = action;
		r.func = func;
		r.offset = offset;
		r.wdata = wdata;
		r.addr = addr;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick, k, l;
		logic [7:0] nb, partner;
		logic [31:0] cur;
		logic [63:0] lo, hi, top;
		r = make_request(pbmd_pkg::ACT_DECODE, 3'($urandom), 8'($urandom), $urandom,
			30'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			// aim at the edges of one bank's window
			k = $urandom_range(0, 7);
			lo = (64'(sb.lane(0, k)) << 20) | (64'(sb.lane(2, k) & 8'h03) << 28);
			hi = (64'(sb.lane(4, k)) << 20) | (64'(sb.lane(6, k) & 8'h03) << 28)
				| 64'(pbmd_pkg::WIN_FILL);
			top = lo + 64'(sb.ram_size) - 1;
			case ($urandom_range(0, 7))
				0: r.addr = 30'(lo);
				1: r.addr = 30'(lo - 1);
				2: r.addr = 30'(hi);
				3: r.addr = 30'(hi + 1);
				4: r.addr = 30'(top);
				5: r.addr = 30'(top + 1);
				6: r.addr = 30'(lo + 64'($urandom_range(0, 32'(sb.ram_size))));
				default: ;
			endcase
			return r;
		end
		r.func = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'd0;
		if (pick < 65) begin
			// edit one lane so start, end and extension bits stay mostly consistent
			k = $urandom_range(0, 7);
			l = $urandom_range(0, 3);
			cur = sb.bank_regs[k];
			partner = sb.bank_regs[k ^ 4][l * 8 +: 8];
			case (k / 2)
				0: nb = $urandom_range(0, 1) ? 8'($urandom) : partner - 8'($urandom_range(0, 24));
				2: nb = partner + 8'($urandom_range(0, 24));
				default: nb = {6'($urandom), partner[1:0]};
			endcase
			if ($urandom_range(0, 3) == 0)
				cur = $urandom;
			else
				cur[l * 8 +: 8] = nb;
			r.action = pbmd_pkg::ACT_WRITE;
			r.offset = OFF_BANK_FIRST + 8'(k * 4);
			r.wdata = cur;
		end else if (pick < 72) begin
			r.action = pbmd_pkg::ACT_WRITE;
			r.offset = pbmd_pkg::OFF_ENABLE;
			if ($urandom_range(0, 1))
				r.wdata[7:0] = r.wdata[7:0] | 8'($urandom);
		end else if (pick < 90) begin
			r.action = pbmd_pkg::ACT_READ;
			case ($urandom_range(0, 3))
				0: r.offset = OFF_BANK_FIRST + 8'($urandom_range(0, 7) * 4);
				1: r.offset = pbmd_pkg::OFF_ENABLE;
				2: r.offset = FIXED_OFFSETS[$urandom_range(0, 7)];
				default: ;
			endcase
		end else if (pick < 96) begin
			r.action = pbmd_pkg::ACT_WRITE;
		end else begin
			r.action = ACT_NONE;
		end
		return r;
	endfunction

	task automatic send_request(request_t r);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.action;
		s_tdata <= {7'd0, r.addr, r.wdata, r.offset, r.func};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
		burst_left--;
	endtask

	// Hold the sender until every pending result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(logic idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(idx, val);
	endtask

	initial begin
		logic [31:0] ram_bytes, base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (FIXED_OFFSETS[i])
			send_request(make_request(pbmd_pkg::ACT_READ, 3'd0, FIXED_OFFSETS[i], $urandom,
				30'($urandom)));
		send_request(make_request(pbmd_pkg::ACT_READ, 3'd0, OFF_BANK_FIRST + 8'd1, $urandom, '0));
		// banks 0-3 start at 0..3 MiB with overlapping ends; banks 4-7 too short at the top
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_FIRST, 32'h0302_0100, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_FIRST + 8'h10,
			32'h0503_0201, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_FIRST + 8'h04, '1, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_FIRST + 8'h0C, '1, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_FIRST + 8'h14, '1, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_BANK_LAST, '1, '0));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, pbmd_pkg::OFF_ENABLE,
			32'hFFFF_FF1F, '0));
		send_request(make_request(pbmd_pkg::ACT_READ, 3'd0, pbmd_pkg::OFF_ENABLE, '1, '1));
		send_request(make_request(pbmd_pkg::ACT_DECODE, 3'd7, '1, '1, 30'h0015_0000));
		send_request(make_request(pbmd_pkg::ACT_DECODE, 3'd0, '0, '0, '1));
		send_request(make_request(pbmd_pkg::ACT_DECODE, 3'd0, '0, '0, '0));
		send_request(make_request(pbmd_pkg::ACT_DECODE, 3'd0, '0, '0, 30'h005F_FFFF));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd3, pbmd_pkg::OFF_ENABLE, '0, '0));
		send_request(make_request(pbmd_pkg::ACT_READ, 3'd5, pbmd_pkg::OFF_ID, '0, '0));
		send_request(make_request(ACT_NONE, '1, '1, '1, '1));
		send_request(make_request(pbmd_pkg::ACT_WRITE, 3'd0, OFF_UNUSED, 32'hDEAD_BEEF, '0));

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin ram_bytes = 32'd1048576; base = 32'd255; end
				1: begin ram_bytes = 32'd1073741824; base = 32'd0; end
				2: begin
					ram_bytes = $urandom_range(1048576, 1073741824);
					base = $urandom_range(0, 255);
				end
				3: begin ram_bytes = $urandom_range(1048576, 67108864); base = 32'd1; end
				default: begin ram_bytes = 32'd1073741824; base = $urandom_range(1, 255); end
			endcase
			write_register(pbmd_pkg::CFG_RAM_SIZE, ram_bytes);
			write_register(pbmd_pkg::CFG_NUM_BASE, base);
			cfg_valid <= 1'b0;
			repeat (ITEMS_PER_PHASE)
				send_request(random_request());
		end

		wait_idle();
		repeat (6) @(posedge clk);
		if (sb.errors == 0 && sb.expected_responses.size() == 0) begin
			$display("pci_bridge_memory_bank_decoder_test passed");
		end else begin
			$display("pci_bridge_memory_bank_decoder_test failed");
		end
		$finish;
	end

endmodule
